// File: hw/rtl/unique_id_generator_top_macros.svh
// Assertion macros shared by the unique ID generator RTL.
// Included by modules that carry concurrent checks; needs no package.
`ifndef UNIQUE_ID_GENERATOR_TOP_MACROS_SVH
`define UNIQUE_ID_GENERATOR_TOP_MACROS_SVH

`ifndef SYNTH
`define UIG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("uig: implication check failed");
`define UIG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("uig: next-cycle check failed");
`define UIG_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("uig: forbidden condition seen");
`else
`define UIG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define UIG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define UIG_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// File: hw/rtl/uig_pkg.sv
// Shared types, constants and helpers for the unique ID generator.
// No dependencies; imported by every uig module.
package uig_pkg;

	localparam int ID_WIDTH    = 64;
	localparam int TIME_W      = 64;
	localparam int FW_W        = 7;
	localparam int BUF_W       = 8;
	localparam int STATUS_W    = 2;
	localparam int TOTAL_W     = 9;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 72;
	localparam int CFG_IDX_W   = 3;
	localparam int REM_W       = 10;

	localparam logic [CFG_IDX_W-1:0] REG_TIMESTAMP_BITS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_BITS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MACHINE_BITS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MACHINE_NUMBER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_OFFSET    = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BEHIND    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BEHIND_1S = 2'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_SMALL = 2'd3;

	localparam logic [REM_W-1:0] MS_PER_S = 10'd1000;

	localparam logic [FW_W-1:0] RST_TIMESTAMP_BITS = 7'd41;
	localparam logic [FW_W-1:0] RST_SEQUENCE_BITS  = 7'd12;
	localparam logic [FW_W-1:0] RST_MACHINE_BITS   = 7'd10;

	typedef struct packed {
		logic [FW_W-1:0]   timestamp_bits;
		logic [FW_W-1:0]   sequence_bits;
		logic [FW_W-1:0]   machine_bits;
		logic [TIME_W-1:0] machine_number;
	} uig_cfg_t;

	// request after the front stage: rebased time plus the size verdict
	typedef struct packed {
		logic              too_small;
		logic [TIME_W-1:0] ts;
	} uig_req_t;

	function automatic logic [TIME_W-1:0] low_mask(input logic [FW_W-1:0] w);
		logic [TIME_W-1:0] m;
		if (w >= FW_W'(TIME_W)) begin
			m = '1;
		end else begin
			m = (TIME_W'(1) << w) - TIME_W'(1);
		end
		return m;
	endfunction

endpackage

// File: hw/rtl/uig_offset_floor.sv
// Floors the epoch offset to whole seconds: folds the offset into a small residue
// by byte weights, then takes its remainder by reciprocal multiply. Depends on uig_pkg.
module uig_offset_floor (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic [uig_pkg::TIME_W-1:0] load_value,
	output logic                      busy,
	output logic [uig_pkg::TIME_W-1:0] floor_ms
);
	import uig_pkg::*;

	localparam int SUM_W    = 20;
	localparam int WT_W     = 10;
	localparam int RECIP_W  = 21;
	localparam int RECIP_SH = 30;
	localparam int PROD_W   = SUM_W + RECIP_W;

	// 256^k mod 1000 for byte k of the offset, byte 0 in the low bits
	localparam logic [8*WT_W-1:0] BYTE_WT = {10'd936, 10'd656, 10'd776, 10'd296,
		10'd216, 10'd536, 10'd256, 10'd1};
	// ceil(2^30 / 1000): exact quotient for any residue below 2^20
	localparam logic [RECIP_W-1:0] RECIP_1000 = 21'd1073742;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_FOLD = 2'd1;
	localparam logic [1:0] PH_QUOT = 2'd2;
	localparam logic [1:0] PH_SUB  = 2'd3;

	logic [TIME_W-1:0] off_q;
	logic [1:0]        phase_q;
	logic [SUM_W-1:0]  sum_q;
	logic [REM_W-1:0]  quot_q;
	logic [TIME_W-1:0] floor_q;

	logic [SUM_W-1:0]  fold;
	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0]  rem_full;

	// residue congruent to the offset mod 1000, at most 255 * 3673
	always_comb begin
		fold = '0;
		for (int k = 0; k < 8; k++) begin
			fold = fold + SUM_W'(off_q[8*k +: 8]) * SUM_W'(BYTE_WT[WT_W*k +: WT_W]);
		end
	end

	assign prod     = PROD_W'(sum_q) * PROD_W'(RECIP_1000);
	assign rem_full = sum_q - SUM_W'(quot_q) * SUM_W'(MS_PER_S);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			phase_q <= PH_IDLE;
			sum_q   <= '0;
			quot_q  <= '0;
			floor_q <= '0;
		end else if (load) begin
			off_q   <= load_value;
			phase_q <= PH_FOLD;
		end else begin
			unique case (phase_q)
				PH_FOLD: begin
					sum_q   <= fold;
					phase_q <= PH_QUOT;
				end
				PH_QUOT: begin
					quot_q  <= prod[RECIP_SH +: REM_W];
					phase_q <= PH_SUB;
				end
				PH_SUB: begin
					floor_q <= off_q - TIME_W'(rem_full[REM_W-1:0]);
					phase_q <= PH_IDLE;
				end
				PH_IDLE: ;
			endcase
		end
	end

	assign busy     = (phase_q != PH_IDLE);
	assign floor_ms = floor_q;

endmodule

// File: hw/rtl/uig_front.sv
// Input stage: rebases the request time and checks the buffer size.
// Depends on uig_pkg.
module uig_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [uig_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	input  uig_pkg::uig_cfg_t             cfg,
	input  logic [uig_pkg::TIME_W-1:0]    floor_ms,
	input  logic                          hold,
	input  logic                          adv,
	output logic                          req_valid,
	output uig_pkg::uig_req_t             req
);
	import uig_pkg::*;

	logic              valid_s1;
	uig_req_t          req_s1;
	logic [TIME_W-1:0] now_ms;
	logic [BUF_W-1:0]  buffer_bytes;
	logic [TOTAL_W-1:0] total;
	logic [TOTAL_W-1:0] need;
	logic              too_small;

	assign now_ms       = s_axis_tdata[TIME_W-1:0];
	assign buffer_bytes = s_axis_tdata[TIME_W+BUF_W-1:TIME_W];

	assign total = TOTAL_W'(cfg.timestamp_bits) + TOTAL_W'(cfg.sequence_bits)
		+ TOTAL_W'(cfg.machine_bits);
	assign need  = (total + TOTAL_W'(7)) >> 3;
	assign too_small = (total > TOTAL_W'(ID_WIDTH)) || (TOTAL_W'(buffer_bytes) < need);

	assign s_axis_tready = !hold && (!valid_s1 || adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1.too_small <= too_small;
			req_s1.ts        <= now_ms - floor_ms;
		end
	end

	assign req_valid = valid_s1;
	assign req       = req_s1;

endmodule

// File: hw/rtl/uig_issue.sv
// Issue stage: clock checks, sequence state, field packing, output register.
// Depends on uig_pkg and unique_id_generator_top_macros.svh.
`include "unique_id_generator_top_macros.svh"
module uig_issue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  uig_pkg::uig_req_t              req,
	input  uig_pkg::uig_cfg_t              cfg,
	output logic                           adv,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [uig_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import uig_pkg::*;

	localparam int PAD_W = OUT_TDATA_W - ID_WIDTH - STATUS_W;

	logic                m_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [ID_WIDTH-1:0] word_q;

	logic [TIME_W-1:0]   last_time_q;
	logic [TIME_W-1:0]   last_m1000_q;
	logic                last_ge1000_q;
	logic [TIME_W-1:0]   seq_q;
	logic                exh_q;

	logic                take;
	logic                same;
	logic [STATUS_W-1:0] status;
	logic [TIME_W-1:0]   emit_seq;
	logic [TIME_W-1:0]   seq_inc;
	logic [TIME_W-1:0]   next_seq;
	logic                next_exh;
	logic [TOTAL_W-1:0]  end_ts;
	logic [TOTAL_W-1:0]  end_seq;
	logic [TOTAL_W-1:0]  end_mach;
	logic [ID_WIDTH-1:0] ts_field;
	logic [ID_WIDTH-1:0] seq_field;
	logic [ID_WIDTH-1:0] mach_field;
	logic [ID_WIDTH-1:0] word;

	assign adv  = !m_valid_q || m_axis_tready;
	assign take = req_valid && adv;
	assign same = (req.ts == last_time_q);

	always_comb begin
		priority if (req.too_small) begin
			status = ST_TOO_SMALL;
		end else if (last_ge1000_q && (req.ts < last_m1000_q)) begin
			status = ST_BEHIND_1S;
		end else if (req.ts < last_time_q) begin
			status = ST_BEHIND;
		end else if (same && exh_q) begin
			status = ST_BEHIND;
		end else begin
			status = ST_OK;
		end
	end

	assign seq_inc  = (seq_q + TIME_W'(1)) & low_mask(cfg.sequence_bits);
	assign emit_seq = same ? seq_q : '0;
	assign next_seq = same ? seq_inc : TIME_W'(1);
	assign next_exh = same && (seq_inc == '0);

	// left-aligned fields: the shift drops timestamp bits above its width, masks trim the rest
	assign end_ts   = TOTAL_W'(cfg.timestamp_bits);
	assign end_seq  = end_ts + TOTAL_W'(cfg.sequence_bits);
	assign end_mach = end_seq + TOTAL_W'(cfg.machine_bits);

	assign ts_field   = req.ts << (TOTAL_W'(ID_WIDTH) - end_ts);
	assign seq_field  = (cfg.sequence_bits == '0) ? '0
		: (emit_seq & low_mask(cfg.sequence_bits)) << (TOTAL_W'(ID_WIDTH) - end_seq);
	assign mach_field = (cfg.machine_bits == '0) ? '0
		: (cfg.machine_number & low_mask(cfg.machine_bits)) << (TOTAL_W'(ID_WIDTH) - end_mach);
	assign word = ts_field | seq_field | mach_field;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q     <= 1'b0;
			last_time_q   <= '0;
			last_m1000_q  <= '0;
			last_ge1000_q <= 1'b0;
			seq_q         <= '0;
			exh_q         <= 1'b0;
		end else begin
			if (adv) begin
				m_valid_q <= req_valid;
			end
			if (take && (status == ST_OK)) begin
				if (!same) begin
					last_time_q   <= req.ts;
					last_m1000_q  <= req.ts - TIME_W'(MS_PER_S);
					last_ge1000_q <= (req.ts >= TIME_W'(MS_PER_S));
				end
				seq_q <= next_seq;
				exh_q <= next_exh;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q <= status;
			word_q   <= (status == ST_OK) ? word : '0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, word_q, status_q};

	`UIG_ASSERT_IMPLIES(a_err_word_zero, clk, arst_n, m_valid_q && (status_q != ST_OK), word_q == '0)
	`UIG_ASSERT_IMPLIES(a_exh_at_wrap, clk, arst_n, exh_q, seq_q == '0)
	`UIG_ASSERT_NEXT(a_time_monotonic, clk, arst_n, take, last_time_q >= $past(last_time_q))

endmodule

// File: hw/rtl/unique_id_generator_top.sv
// Top level of the unique ID generator: config registers, offset floor unit,
// front stage and issue stage. Depends on uig_pkg, the uig modules and the macro header.
//
//  channel    | direction | handshake                    | payload
//  s_axis     | in        | s_axis_tvalid/s_axis_tready  | tdata: now_ms, buffer_bytes
//  m_axis     | out       | m_axis_tvalid/m_axis_tready  | tdata: status, id_word
//  cfg        | in        | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
// One request per cycle unless the floor unit or m_axis_tready stalls the pipe.
// Reset loads the field widths 41/12/10, machine number and offset zero, and
// clears the last time, sequence counter and exhausted flag.
// The output register and the front register let a new transaction in while a
// result waits on m_axis_tready; a full pipe stalls s_axis_tready.
// Writing time_offset_ms starts the seconds floor unit: s_axis_tready stays low
// while it runs the byte fold, reciprocal quotient and subtract steps.
`include "unique_id_generator_top_macros.svh"
module unique_id_generator_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [63:0] now_ms, [71:64] buffer_bytes
	input  logic [uig_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [1:0] status, [65:2] id_word, [71:66] zero
	output logic [uig_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [uig_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [uig_pkg::TIME_W-1:0]      cfg_data
);
	import uig_pkg::*;

	uig_cfg_t          cfg_q;
	logic              cfg_wr;
	logic              div_busy;
	logic [TIME_W-1:0] floor_ms;
	logic              req_valid;
	uig_req_t          req;
	logic              adv;

	// config writes are always taken; writes to unused indexes are dropped
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timestamp_bits <= RST_TIMESTAMP_BITS;
			cfg_q.sequence_bits  <= RST_SEQUENCE_BITS;
			cfg_q.machine_bits   <= RST_MACHINE_BITS;
			cfg_q.machine_number <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_TIMESTAMP_BITS: cfg_q.timestamp_bits <= cfg_data[FW_W-1:0];
				REG_SEQUENCE_BITS:  cfg_q.sequence_bits  <= cfg_data[FW_W-1:0];
				REG_MACHINE_BITS:   cfg_q.machine_bits   <= cfg_data[FW_W-1:0];
				REG_MACHINE_NUMBER: cfg_q.machine_number <= cfg_data;
				default: ;
			endcase
		end
	end

	// the offset itself lives in the floor unit, which keeps the floored copy
	uig_offset_floor u_floor (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (cfg_wr && (cfg_index == REG_TIME_OFFSET)),
		.load_value (cfg_data),
		.busy       (div_busy),
		.floor_ms   (floor_ms)
	);

	uig_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.cfg           (cfg_q),
		.floor_ms      (floor_ms),
		.hold          (div_busy),
		.adv           (adv),
		.req_valid     (req_valid),
		.req           (req)
	);

	uig_issue u_issue (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req           (req),
		.cfg           (cfg_q),
		.adv           (adv),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// no request may enter while the floored offset is being recomputed
	`UIG_ASSERT_NEVER(a_no_accept_while_flooring, clk, arst_n, div_busy && s_axis_tready)

endmodule
